/* rtl/tts_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tts_pkg
// Shared types and constants of the timer task scheduler: request codes,
// field widths and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package tts_pkg;

	localparam int FUNC_W  = 3;
	localparam int TASK_W  = 8;
	localparam int DELAY_W = 32;
	localparam int LOST_W  = 5;

	localparam logic [FUNC_W-1:0] FUNC_ENQUEUE  = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_ARM      = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_CANCEL   = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_DISPATCH = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_TICK     = 3'd4;

	localparam logic [LOST_W-1:0] LOST_MAX = 5'd31;

	typedef struct packed {
		logic latch;
		logic enq;
		logic scan_clr;
		logic scan_run;
		logic arm_wr;
		logic deq_pop;
		logic load_out;
	} tts_cmd_t;

	typedef struct packed {
		logic is_enq;
		logic is_arm;
		logic is_cancel;
		logic is_disp;
		logic is_tick;
		logic id_zero;
		logic fifo_empty;
		logic scan_last;
	} tts_sts_t;

endpackage
`default_nettype wire

/* rtl/tts_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tts_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module tts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

/* rtl/tts_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tts_ctrl
// Request sequencer: accepts a beat, steps the datapath through the request
// and hands the result to the output register.
// ----------------------------------------------------------------------------
module tts_ctrl
	import tts_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     req_valid,
	output logic          req_stall,
	output logic          rsp_valid,
	input  wire logic     rsp_stall,
	input  wire tts_sts_t sts,
	output tts_cmd_t      cmd
);

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_DECODE = 6'b000010,
		ST_SCAN   = 6'b000100,
		ST_ARM_WR = 6'b001000,
		ST_DEQ    = 6'b010000,
		ST_DONE   = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.latch = 1'b1;
					state_d   = ST_DECODE;
				end
			end
			ST_DECODE: begin
				priority if (sts.is_enq) begin
					cmd.enq = 1'b1;
					state_d = ST_DONE;
				end else if (((sts.is_arm || sts.is_cancel) && !sts.id_zero) || sts.is_tick) begin
					cmd.scan_clr = 1'b1;
					state_d      = ST_SCAN;
				end else if (sts.is_disp && !sts.fifo_empty) begin
					state_d = ST_DEQ;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_SCAN: begin
				cmd.scan_run = 1'b1;
				if (sts.scan_last) begin
					state_d = sts.is_arm ? ST_ARM_WR : ST_DONE;
				end
			end
			ST_ARM_WR: begin
				cmd.arm_wr = 1'b1;
				state_d    = ST_DONE;
			end
			ST_DEQ: begin
				cmd.deq_pop = 1'b1;
				state_d     = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || !rsp_stall) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = out_valid_q;

endmodule
`default_nettype wire

/* rtl/tts_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tts_dp
// Datapath: request registers, circular task queue in RAM, timer slot RAM
// with per-slot armed flags, slot walker and result/output registers.
// ----------------------------------------------------------------------------
module tts_dp
	import tts_pkg::*;
#(
	parameter int QUEUE_DEPTH = 16,
	parameter int TIMER_SLOTS = 16,
	parameter int ID_BITS     = 8
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire tts_cmd_t           cmd,
	output tts_sts_t                sts,
	input  wire logic [FUNC_W-1:0]  func,
	input  wire logic [TASK_W-1:0]  task_id,
	input  wire logic [DELAY_W-1:0] delay_ticks,
	output logic      [TASK_W-1:0]  run_task,
	output logic                    run_valid,
	output logic                    stored,
	output logic      [LOST_W-1:0]  lost_count
);

	localparam int QAW = $clog2(QUEUE_DEPTH);
	localparam int QCW = $clog2(QUEUE_DEPTH + 1);
	localparam int TAW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
	localparam int TCW = $clog2(TIMER_SLOTS + 1);
	localparam int TW  = ID_BITS + DELAY_W;

	// request
	logic [FUNC_W-1:0]  func_q;
	logic [ID_BITS-1:0] id_q;
	logic [DELAY_W-1:0] delay_q;

	// queue
	logic [QAW-1:0] head_q;
	logic [QCW-1:0] count_q;
	logic [QAW:0]   tail_sum;
	logic [QAW-1:0] tail;
	logic           fifo_full;
	logic           fq_we;
	logic [ID_BITS-1:0] fq_rdata;

	// timer slots
	logic [TIMER_SLOTS-1:0] armed_q;
	logic [TCW-1:0]     issue_q;
	logic               issue_en;
	logic               rd_pend_s1;
	logic [TAW-1:0]     rd_slot_s1;
	logic [TW-1:0]      tm_rdata;
	logic [ID_BITS-1:0] slot_owner;
	logic [DELAY_W-1:0] slot_rem;
	logic               proc;
	logic               slot_armed;
	logic               slot_hit;
	logic               tick_fire;
	logic               tick_dec;
	logic               cancel_clr;
	logic               match_found_q, free_found_q;
	logic [TAW-1:0]     match_slot_q, free_slot_q;
	logic               arm_do;
	logic               tm_we;
	logic [TAW-1:0]     tm_waddr;
	logic [TW-1:0]      tm_wdata;

	// results
	logic [TASK_W-1:0] res_task_q;
	logic              res_valid_q;
	logic              res_stored_q;
	logic [LOST_W-1:0] res_lost_q;
	logic              enq_push;

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			func_q  <= func;
			id_q    <= ID_BITS'(task_id);
			delay_q <= delay_ticks;
		end
	end

	assign sts.is_enq     = (func_q == FUNC_ENQUEUE);
	assign sts.is_arm     = (func_q == FUNC_ARM);
	assign sts.is_cancel  = (func_q == FUNC_CANCEL);
	assign sts.is_disp    = (func_q == FUNC_DISPATCH);
	assign sts.is_tick    = (func_q == FUNC_TICK);
	assign sts.id_zero    = (id_q == '0);
	assign sts.fifo_empty = (count_q == '0);
	assign sts.scan_last  = rd_pend_s1 && (rd_slot_s1 == TAW'(TIMER_SLOTS - 1));

	// queue pointers
	assign tail_sum  = (QAW+1)'(head_q) + (QAW+1)'(count_q);
	assign tail      = (tail_sum >= (QAW+1)'(QUEUE_DEPTH)) ?
		QAW'(tail_sum - (QAW+1)'(QUEUE_DEPTH)) : QAW'(tail_sum);
	assign fifo_full = (count_q == QCW'(QUEUE_DEPTH));

	// slot walk
	assign issue_en   = cmd.scan_run && (issue_q < TCW'(TIMER_SLOTS));
	assign slot_owner = tm_rdata[TW-1:DELAY_W];
	assign slot_rem   = tm_rdata[DELAY_W-1:0];
	assign proc       = cmd.scan_run && rd_pend_s1;
	assign slot_armed = armed_q[rd_slot_s1];
	assign slot_hit   = slot_armed && (slot_owner == id_q);
	assign tick_fire  = proc && sts.is_tick && slot_armed && (slot_rem <= DELAY_W'(1));
	assign tick_dec   = proc && sts.is_tick && slot_armed && (slot_rem > DELAY_W'(1));
	assign cancel_clr = proc && sts.is_cancel && slot_hit && !match_found_q;
	assign arm_do     = cmd.arm_wr && (match_found_q || free_found_q);

	assign enq_push = cmd.enq && !sts.id_zero && !fifo_full;
	assign fq_we    = (enq_push || tick_fire) && !fifo_full;

	always_comb begin
		tm_we    = 1'b0;
		tm_waddr = rd_slot_s1;
		tm_wdata = {slot_owner, slot_rem - DELAY_W'(1)};
		if (tick_dec) begin
			tm_we = 1'b1;
		end else if (arm_do) begin
			tm_we    = 1'b1;
			tm_waddr = match_found_q ? match_slot_q : free_slot_q;
			tm_wdata = {id_q, delay_q};
		end
	end

	tts_ram #(
		.WIDTH(ID_BITS),
		.DEPTH(QUEUE_DEPTH)
	) u_queue_ram (
		.clk  (clk),
		.we   (fq_we),
		.waddr(tail),
		.wdata(tick_fire ? slot_owner : id_q),
		.raddr(head_q),
		.rdata(fq_rdata)
	);

	tts_ram #(
		.WIDTH(TW),
		.DEPTH(TIMER_SLOTS)
	) u_timer_ram (
		.clk  (clk),
		.we   (tm_we),
		.waddr(tm_waddr),
		.wdata(tm_wdata),
		.raddr(issue_q[TAW-1:0]),
		.rdata(tm_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q     <= '0;
			count_q    <= '0;
			armed_q    <= '0;
			issue_q    <= '0;
			rd_pend_s1 <= 1'b0;
		end else begin
			rd_pend_s1 <= issue_en;
			if (cmd.scan_clr) begin
				issue_q <= '0;
			end else if (issue_en) begin
				issue_q <= issue_q + 1'b1;
			end
			if (fq_we) begin
				count_q <= count_q + 1'b1;
			end else if (cmd.deq_pop) begin
				count_q <= count_q - 1'b1;
				head_q  <= (head_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
			end
			if (tick_fire || cancel_clr) begin
				armed_q[rd_slot_s1] <= 1'b0;
			end else if (arm_do && !match_found_q) begin
				armed_q[free_slot_q] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_slot_s1 <= issue_q[TAW-1:0];
		if (cmd.scan_clr) begin
			match_found_q <= 1'b0;
			free_found_q  <= 1'b0;
		end else if (proc) begin
			if (slot_hit && !match_found_q) begin
				match_found_q <= 1'b1;
				match_slot_q  <= rd_slot_s1;
			end
			if (!slot_armed && !free_found_q) begin
				free_found_q <= 1'b1;
				free_slot_q  <= rd_slot_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			res_task_q   <= '0;
			res_valid_q  <= 1'b0;
			res_stored_q <= 1'b0;
			res_lost_q   <= '0;
		end else begin
			if (enq_push || cancel_clr || arm_do) begin
				res_stored_q <= 1'b1;
			end
			if (tick_fire && fifo_full && (res_lost_q != LOST_MAX)) begin
				res_lost_q <= res_lost_q + 1'b1;
			end
			if (cmd.deq_pop) begin
				res_task_q  <= TASK_W'(fq_rdata);
				res_valid_q <= 1'b1;
			end
		end
		if (cmd.load_out) begin
			run_task   <= res_task_q;
			run_valid  <= res_valid_q;
			stored     <= res_stored_q;
			lost_count <= res_lost_q;
		end
	end

endmodule
`default_nettype wire

/* rtl/timer_task_scheduler_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// timer_task_scheduler_core
// Task queue with one-shot software timers: enqueue, arm, cancel, dispatch
// and tick requests, one result beat per request beat.
// Request path: enqueue, unused codes, arm or cancel of id 0 and dispatch of
// an empty queue go from decode straight to the result; dispatch first pops
// the queue; cancel and tick walk the timer RAM (one slot per cycle on its
// single read port) and arm adds a slot write after the walk; the result waits
// while the previous result is still stalled.
// One request in flight; the next is taken in the cycle after a result is
// registered, even while that result is still stalled.
// Reset: queue empty and all timer slots free at once, no clearing pass.
// ----------------------------------------------------------------------------
module timer_task_scheduler_core
	import tts_pkg::*;
#(
	parameter int QUEUE_DEPTH = 16,
	parameter int TIMER_SLOTS = 16,
	parameter int ID_BITS     = 8
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	output logic                    req_stall,
	input  wire logic [FUNC_W-1:0]  func,
	input  wire logic [TASK_W-1:0]  task_id,
	input  wire logic [DELAY_W-1:0] delay_ticks,
	output logic                    rsp_valid,
	input  wire logic               rsp_stall,
	output logic      [TASK_W-1:0]  run_task,
	output logic                    run_valid,
	output logic                    stored,
	output logic      [LOST_W-1:0]  lost_count
);

	tts_cmd_t cmd;
	tts_sts_t sts;

	tts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	tts_dp #(
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.TIMER_SLOTS(TIMER_SLOTS),
		.ID_BITS    (ID_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.func       (func),
		.task_id    (task_id),
		.delay_ticks(delay_ticks),
		.run_task   (run_task),
		.run_valid  (run_valid),
		.stored     (stored),
		.lost_count (lost_count)
	);

endmodule
`default_nettype wire
